// ===== rtl/core/sifr_pkg.sv =====
// ----------------------------------------------------------------------------
// sifr_pkg
// Shared types and codes of the stuffed information-frame receiver:
// parser phases, register indexes, verdict codes and the result record.
// ----------------------------------------------------------------------------
package sifr_pkg;

    // receive parser phases
    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_FLAG = 3'd1,
        PH_ADDR = 3'd2,
        PH_CTRL = 3'd3,
        PH_DATA = 3'd4,
        PH_ESC  = 3'd5
    } t_phase;

    // configuration register indexes
    localparam int unsigned CfgIdxW = 3;
    typedef enum logic [CfgIdxW-1:0] {
        CFG_FLAG     = 3'd0,
        CFG_ADDRESS  = 3'd1,
        CFG_CTRL_SEQ0 = 3'd2,
        CFG_CTRL_SEQ1 = 3'd3,
        CFG_ESCAPE   = 3'd4,
        CFG_ESC_FLAG = 3'd5,
        CFG_ESC_ESC  = 3'd6
    } t_cfg_idx;

    // configuration reset values
    localparam logic [7:0] RST_FLAG      = 8'h7E;
    localparam logic [7:0] RST_ADDRESS   = 8'h03;
    localparam logic [7:0] RST_CTRL_SEQ0 = 8'h00;
    localparam logic [7:0] RST_CTRL_SEQ1 = 8'h40;
    localparam logic [7:0] RST_ESCAPE    = 8'h7D;
    localparam logic [7:0] RST_ESC_FLAG  = 8'h5E;
    localparam logic [7:0] RST_ESC_ESC   = 8'h5D;

    // result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // frame status codes
    localparam logic [1:0] ST_NEW = 2'd0;
    localparam logic [1:0] ST_DUP = 2'd1;
    localparam logic [1:0] ST_ERR = 2'd2;

    // reply kinds
    localparam logic REPLY_RR  = 1'b0;
    localparam logic REPLY_REJ = 1'b1;

    // configuration register set
    typedef struct packed {
        logic [7:0] flag_byte;
        logic [7:0] address_byte;
        logic [7:0] control_seq0;
        logic [7:0] control_seq1;
        logic [7:0] escape_byte;
        logic [7:0] escaped_flag_code;
        logic [7:0] escaped_escape_code;
    } t_cfg;

    // one result item
    typedef struct packed {
        logic       result_kind;
        logic [7:0] payload_byte;
        logic [1:0] frame_status;
        logic       reply_kind;
        logic       reply_sequence;
        logic       frame_sequence;
    } t_result;

endpackage

// ===== rtl/core/sifr_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// sifr_cfg_regs
// Configuration register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module sifr_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_wr,
    input  logic [sifr_pkg::CfgIdxW-1:0]   i_index,
    input  logic [7:0]                     i_data,
    output sifr_pkg::t_cfg                 o_cfg
);

    sifr_pkg::t_cfg r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.flag_byte           <= sifr_pkg::RST_FLAG;
            r_cfg.address_byte        <= sifr_pkg::RST_ADDRESS;
            r_cfg.control_seq0        <= sifr_pkg::RST_CTRL_SEQ0;
            r_cfg.control_seq1        <= sifr_pkg::RST_CTRL_SEQ1;
            r_cfg.escape_byte         <= sifr_pkg::RST_ESCAPE;
            r_cfg.escaped_flag_code   <= sifr_pkg::RST_ESC_FLAG;
            r_cfg.escaped_escape_code <= sifr_pkg::RST_ESC_ESC;
        end else if (i_wr) begin
            unique case (sifr_pkg::t_cfg_idx'(i_index))
                sifr_pkg::CFG_FLAG:      r_cfg.flag_byte           <= i_data;
                sifr_pkg::CFG_ADDRESS:   r_cfg.address_byte        <= i_data;
                sifr_pkg::CFG_CTRL_SEQ0: r_cfg.control_seq0        <= i_data;
                sifr_pkg::CFG_CTRL_SEQ1: r_cfg.control_seq1        <= i_data;
                sifr_pkg::CFG_ESCAPE:    r_cfg.escape_byte         <= i_data;
                sifr_pkg::CFG_ESC_FLAG:  r_cfg.escaped_flag_code   <= i_data;
                sifr_pkg::CFG_ESC_ESC:   r_cfg.escaped_escape_code <= i_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/sifr_parser.sv =====
// ----------------------------------------------------------------------------
// sifr_parser
// Frame parser: header hunt, destuffing, one-byte delay, trailing check and
// verdict. Produces at most one result per accepted byte.
// ----------------------------------------------------------------------------
module sifr_parser (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sifr_pkg::t_cfg        i_cfg,
    input  logic                  i_acc,
    input  logic [7:0]            i_rx_byte,
    output logic                  o_res_valid,
    output sifr_pkg::t_result     o_res
);

    sifr_pkg::t_phase r_phase, n_phase;
    logic             r_seen_seq, n_seen_seq;
    logic             r_exp_seq, n_exp_seq;
    logic [7:0]       r_xor, n_xor;
    logic [7:0]       r_held, n_held;
    logic [1:0]       r_count, n_count;

    logic       is_flag, is_esc, hdr_ok;
    logic       take, verdict_hit, frame_ok;
    logic [7:0] take_val, ctl_sel;

    // byte classification
    always_comb begin
        is_flag = (i_rx_byte == i_cfg.flag_byte);
        is_esc  = (i_rx_byte == i_cfg.escape_byte);
        ctl_sel = r_seen_seq ? i_cfg.control_seq1 : i_cfg.control_seq0;
        hdr_ok  = (i_rx_byte == (i_cfg.address_byte ^ ctl_sel));
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (i_acc) begin
            unique case (r_phase)
                sifr_pkg::PH_FLAG: begin
                    if (i_rx_byte == i_cfg.address_byte) n_phase = sifr_pkg::PH_ADDR;
                    else if (is_flag)                    n_phase = sifr_pkg::PH_FLAG;
                    else                                 n_phase = sifr_pkg::PH_HUNT;
                end
                sifr_pkg::PH_ADDR: begin
                    if (i_rx_byte == i_cfg.control_seq0 ||
                        i_rx_byte == i_cfg.control_seq1) n_phase = sifr_pkg::PH_CTRL;
                    else if (is_flag)                    n_phase = sifr_pkg::PH_FLAG;
                    else                                 n_phase = sifr_pkg::PH_HUNT;
                end
                sifr_pkg::PH_CTRL: begin
                    n_phase = hdr_ok ? sifr_pkg::PH_DATA : sifr_pkg::PH_HUNT;
                end
                sifr_pkg::PH_DATA: begin
                    if (is_flag)     n_phase = sifr_pkg::PH_HUNT;
                    else if (is_esc) n_phase = sifr_pkg::PH_ESC;
                    else             n_phase = sifr_pkg::PH_DATA;
                end
                sifr_pkg::PH_ESC: begin
                    n_phase = sifr_pkg::PH_DATA;
                end
                default: begin
                    n_phase = is_flag ? sifr_pkg::PH_FLAG : sifr_pkg::PH_HUNT;
                end
            endcase
        end
    end

    // destuffing, check and result
    always_comb begin
        take     = 1'b0;
        take_val = i_rx_byte;
        if (r_phase == sifr_pkg::PH_DATA) begin
            take = !is_flag && !is_esc;
        end else if (r_phase == sifr_pkg::PH_ESC) begin
            priority if (i_rx_byte == i_cfg.escaped_flag_code) begin
                take     = 1'b1;
                take_val = i_cfg.flag_byte;
            end else if (i_rx_byte == i_cfg.escaped_escape_code) begin
                take     = 1'b1;
                take_val = i_cfg.escape_byte;
            end else begin
                take = 1'b0;
            end
        end
        take        = take && i_acc;
        verdict_hit = i_acc && (r_phase == sifr_pkg::PH_DATA) && is_flag;

        // empty frame fails, one-byte frame passes, else xor must be zero
        frame_ok = (r_count == 2'd1) || ((r_count == 2'd2) && (r_xor == 8'd0));

        n_seen_seq = r_seen_seq;
        n_exp_seq  = r_exp_seq;
        n_xor      = r_xor;
        n_held     = r_held;
        n_count    = r_count;

        if (i_acc && r_phase == sifr_pkg::PH_ADDR) begin
            if (i_rx_byte == i_cfg.control_seq0)      n_seen_seq = 1'b0;
            else if (i_rx_byte == i_cfg.control_seq1) n_seen_seq = 1'b1;
        end
        if (i_acc && r_phase == sifr_pkg::PH_CTRL && hdr_ok) begin
            n_xor   = 8'd0;
            n_held  = 8'd0;
            n_count = 2'd0;
        end
        if (take) begin
            n_held = take_val;
            n_xor  = r_xor ^ take_val;
            if (r_count != 2'd2) n_count = r_count + 2'd1;
        end
        if (verdict_hit && frame_ok && (r_seen_seq == r_exp_seq)) begin
            n_exp_seq = ~r_exp_seq;
        end

        o_res_valid = verdict_hit || (take && (r_count != 2'd0));
        o_res       = '0;
        if (verdict_hit) begin
            o_res.result_kind    = sifr_pkg::KIND_VERDICT;
            o_res.reply_kind     = frame_ok ? sifr_pkg::REPLY_RR : sifr_pkg::REPLY_REJ;
            o_res.reply_sequence = ~r_seen_seq;
            o_res.frame_sequence = r_seen_seq;
            if (!frame_ok)                    o_res.frame_status = sifr_pkg::ST_ERR;
            else if (r_seen_seq == r_exp_seq) o_res.frame_status = sifr_pkg::ST_NEW;
            else                              o_res.frame_status = sifr_pkg::ST_DUP;
        end else begin
            o_res.result_kind  = sifr_pkg::KIND_PAYLOAD;
            o_res.payload_byte = r_held;
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= sifr_pkg::PH_HUNT;
            r_seen_seq <= 1'b0;
            r_exp_seq  <= 1'b0;
            r_xor      <= 8'd0;
            r_held     <= 8'd0;
            r_count    <= 2'd0;
        end else begin
            r_phase    <= n_phase;
            r_seen_seq <= n_seen_seq;
            r_exp_seq  <= n_exp_seq;
            r_xor      <= n_xor;
            r_held     <= n_held;
            r_count    <= n_count;
        end
    end

endmodule

// ===== rtl/core/sifr_out_buf.sv =====
// ----------------------------------------------------------------------------
// sifr_out_buf
// Two-entry result buffer: output register plus skid register, so the
// input side keeps flowing while a result waits downstream.
// ----------------------------------------------------------------------------
module sifr_out_buf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  sifr_pkg::t_result  i_data,
    output logic               o_full,
    output logic               o_valid,
    input  logic               i_stall,
    output sifr_pkg::t_result  o_data
);

    logic              r_main_valid, r_skid_valid;
    sifr_pkg::t_result r_main, r_skid;
    logic              pop;

    assign pop = r_main_valid && !i_stall;

    // control bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) r_skid_valid <= 1'b0;
        end else if (i_push) begin
            if (r_main_valid && !pop) r_skid_valid <= 1'b1;
            else                      r_main_valid <= 1'b1;
        end else if (pop) begin
            r_main_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) r_main <= r_skid;
        end else if (i_push) begin
            if (r_main_valid && !pop) r_skid <= i_data;
            else                      r_main <= i_data;
        end
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;

endmodule

// ===== rtl/core/stuffed_iframe_receiver_unit.sv =====
// ----------------------------------------------------------------------------
// stuffed_iframe_receiver_unit
// Each result is registered in the result buffer (output or skid register) before it shows on the output.
// Throughput: one line byte per cycle; the parser state updates in one pass.
// The input stalls only while both result buffer entries are occupied.
// Reset (synchronous, active low) restores register defaults, hunting phase,
// sequence bits to zero and an empty result buffer.
// ----------------------------------------------------------------------------
module stuffed_iframe_receiver_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // line byte input
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [7:0]                    i_rx_byte,
    // result output
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_result_kind,
    output logic [7:0]                    o_payload_byte,
    output logic [1:0]                    o_frame_status,
    output logic                          o_reply_kind,
    output logic                          o_reply_sequence,
    output logic                          o_frame_sequence,
    // configuration writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [sifr_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [7:0]                    i_cfg_data
);

    sifr_pkg::t_cfg    cfg;
    sifr_pkg::t_result res, out_res;
    logic              res_valid, buf_full, in_acc;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = buf_full;
    assign in_acc      = i_in_valid && !buf_full;

    // configuration registers
    sifr_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // frame parser
    sifr_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_acc       (in_acc),
        .i_rx_byte   (i_rx_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // result buffer
    sifr_out_buf u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .o_full  (buf_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (out_res)
    );

    assign o_result_kind    = out_res.result_kind;
    assign o_payload_byte   = out_res.payload_byte;
    assign o_frame_status   = out_res.frame_status;
    assign o_reply_kind     = out_res.reply_kind;
    assign o_reply_sequence = out_res.reply_sequence;
    assign o_frame_sequence = out_res.frame_sequence;

endmodule
